[hw/rtl/assert_macros.svh]
// Assertion macros used by set_assoc_lru_cache_model_core.
// No dependencies; SYNTH selects the empty forms for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked property, disabled while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[hw/rtl/salc_pkg.sv]
// Shared constants and types for the set-associative LRU cache model.
// No dependencies.
`default_nettype none

package salc_pkg;

   // Defaults of the top-level parameters
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;
   localparam int ADDR_WIDTH_DEF   = 64;

   // Fixed field widths
   localparam int REQ_ADDR_WIDTH   = 64;
   localparam int KIND_WIDTH       = 2;
   localparam int COUNT_WIDTH      = 32;
   localparam int STAMP_WIDTH      = 64;
   localparam int SET_BITS_WIDTH   = 3;
   localparam int BLOCK_BITS_WIDTH = 6;
   localparam int WAYS_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 6;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAYS       = 2'd2;

   // Access kinds (load and store behave alike; unused code acts as load)
   localparam logic [KIND_WIDTH-1:0] KIND_MODIFY = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EVAL  = 3'b100
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/salc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/set_assoc_lru_cache_model_core.sv]
// Top level of the set-associative LRU cache model.
// Depends on salc_pkg, salc_ram and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Set-associative cache tracker with least-recently-used replacement. Each
// request beat carries an access kind and a byte address; the address is cut
// to ADDR_WIDTH bits and split into block offset, set index and tag from the
// csr_ registers. One response beat comes back per request with the hit and
// eviction flags and the running hit, miss and eviction totals (32-bit, wrap).
// All ways of one set sit in one row of a single RAM (valid, tag and 64-bit
// timestamp per way), so one read brings in the whole set. In the accept
// cycle the set row is read; in the evaluation state the ways are compared
// in parallel (tag match, first free way, oldest timestamp with ties to the
// lowest way) and the updated row is written back. A response beat that
// waits on rsp_stall holds the evaluation, but the next request is still
// taken as soon as the row has been written. After reset the block runs a
// clearing pass over every row of the set RAM, one row a cycle, during
// which req_stall stays high; csr writes are taken at any time.
// Registers may be changed only while the block is idle; lines are not
// flushed when they change.
module set_assoc_lru_cache_model_core
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = MAX_WAYS_DEF,
   parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]   csr_wr_data,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [KIND_WIDTH-1:0]       req_kind,
   input  wire logic [REQ_ADDR_WIDTH-1:0]   req_address,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_hit,
   output logic                             rsp_evicted,
   output logic      [COUNT_WIDTH-1:0]      rsp_hit_total,
   output logic      [COUNT_WIDTH-1:0]      rsp_miss_total,
   output logic      [COUNT_WIDTH-1:0]      rsp_eviction_total
);

   localparam int SET_AW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int RAM_DEPTH = 1 << SET_AW;
   localparam int LINE_W    = 1 + ADDR_WIDTH + STAMP_WIDTH;
   localparam int ROW_W     = MAX_WAYS * LINE_W;
   // line layout inside a row: {stamp, tag, valid}
   localparam int TAG_LSB   = 1;
   localparam int STAMP_LSB = 1 + ADDR_WIDTH;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type                      state_ff, state_in;
   logic [SET_AW-1:0]              clr_ptr_ff, clr_ptr_in;
   logic [SET_BITS_WIDTH-1:0]      set_bits_ff;
   logic [BLOCK_BITS_WIDTH-1:0]    block_bits_ff;
   logic [WAYS_WIDTH-1:0]          ways_ff;
   logic [STAMP_WIDTH-1:0]         clock_ff, clock_in;
   logic [COUNT_WIDTH-1:0]         hit_cnt_ff, hit_cnt_in;
   logic [COUNT_WIDTH-1:0]         miss_cnt_ff, miss_cnt_in;
   logic [COUNT_WIDTH-1:0]         evict_cnt_ff, evict_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   // item registers (payload, no reset)
   logic [KIND_WIDTH-1:0]          kind_ff;
   logic [SET_AW-1:0]              set_ff;
   logic [ADDR_WIDTH-1:0]          tag_ff;
   logic                           rsp_hit_ff, rsp_evicted_ff;

   // ------------------------------------------------------------------
   // Address split
   // ------------------------------------------------------------------
   logic [SET_BITS_WIDTH-1:0]      sb_eff;
   logic [ADDR_WIDTH-1:0]          addr_cut;
   logic [ADDR_WIDTH-1:0]          addr_shift;
   logic [SET_AW-1:0]              set_mask;
   logic [SET_AW-1:0]              req_set;
   logic [ADDR_WIDTH-1:0]          req_tag;

   always_comb begin
      if (32'(set_bits_ff) > MAX_SET_BITS) begin
         sb_eff = SET_BITS_WIDTH'(MAX_SET_BITS);
      end else begin
         sb_eff = set_bits_ff;
      end
      addr_cut   = req_address[ADDR_WIDTH-1:0];
      addr_shift = addr_cut >> block_bits_ff;
      for (int i = 0; i < SET_AW; i++) begin
         set_mask[i] = (i < int'(sb_eff));
      end
      req_set = addr_shift[SET_AW-1:0] & set_mask;
      // shifting the already shifted word drops everything past the top
      req_tag = addr_shift >> sb_eff;
   end

   // ------------------------------------------------------------------
   // Set RAM
   // ------------------------------------------------------------------
   logic                 ram_wr_en;
   logic [SET_AW-1:0]    ram_wr_addr;
   logic [ROW_W-1:0]     ram_wr_data;
   logic                 ram_rd_en;
   logic [ROW_W-1:0]     ram_rd_data;
   logic [ROW_W-1:0]     row_new;

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (RAM_DEPTH)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_set),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Way evaluation on the row read back
   // ------------------------------------------------------------------
   logic                     way_valid [MAX_WAYS];
   logic [ADDR_WIDTH-1:0]    way_tag   [MAX_WAYS];
   logic [STAMP_WIDTH-1:0]   way_stamp [MAX_WAYS];
   logic [MAX_WAYS-1:0]      way_on;
   logic [MAX_WAYS-1:0]      hit_vec, hit_oh;
   logic [MAX_WAYS-1:0]      free_vec, free_oh;
   logic [MAX_WAYS-1:0]      lru_oh;
   logic [MAX_WAYS-1:0]      sel_oh;
   logic                     hit_any, free_any, evict;
   logic                     is_modify;
   logic [STAMP_WIDTH-1:0]   stamp_new;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_valid[w] = ram_rd_data[w*LINE_W];
         way_tag[w]   = ram_rd_data[w*LINE_W + TAG_LSB +: ADDR_WIDTH];
         way_stamp[w] = ram_rd_data[w*LINE_W + STAMP_LSB +: STAMP_WIDTH];
         // zero ways acts as one, too many as all
         way_on[w]    = (w == 0) || (32'(ways_ff) > w);
         hit_vec[w]   = way_on[w] && way_valid[w] && (way_tag[w] == tag_ff);
         free_vec[w]  = way_on[w] && !way_valid[w];
      end
      // keep the lowest matching way
      hit_oh   = hit_vec & (~hit_vec + MAX_WAYS'(1));
      free_oh  = free_vec & (~free_vec + MAX_WAYS'(1));
      hit_any  = |hit_vec;
      free_any = |free_vec;

      // oldest stamp: strictly older than every lower way, no newer than
      // every higher way, so ties go to the lowest way
      for (int w = 0; w < MAX_WAYS; w++) begin
         lru_oh[w] = way_on[w];
         for (int v = 0; v < MAX_WAYS; v++) begin
            if (way_on[v] && (v < w)) begin
               lru_oh[w] = lru_oh[w] && (way_stamp[w] < way_stamp[v]);
            end else if (way_on[v] && (v > w)) begin
               lru_oh[w] = lru_oh[w] && (way_stamp[w] <= way_stamp[v]);
            end
         end
      end

      if (hit_any) begin
         sel_oh = hit_oh;
      end else if (free_any) begin
         sel_oh = free_oh;
      end else begin
         sel_oh = lru_oh;
      end
      evict     = !hit_any && !free_any;
      is_modify = (kind_ff == KIND_MODIFY);
      // a modify stamps the line a second time
      stamp_new = clock_ff + (is_modify ? STAMP_WIDTH'(2) : STAMP_WIDTH'(1));

      row_new = ram_rd_data;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (sel_oh[w]) begin
            row_new[w*LINE_W + STAMP_LSB +: STAMP_WIDTH] = stamp_new;
            row_new[w*LINE_W + TAG_LSB +: ADDR_WIDTH]    = tag_ff;
            row_new[w*LINE_W]                            = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   logic req_take;
   logic out_free;
   logic eval_adv;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign eval_adv  = (state_ff == ST_EVAL) && out_free;
   assign ram_rd_en = req_take;

   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      clock_in     = clock_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = set_ff;
      ram_wr_data  = row_new;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_CLEAR: begin
            // wipe one row a cycle
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ptr_ff;
            ram_wr_data = '0;
            clr_ptr_in  = clr_ptr_ff + SET_AW'(1);
            if (clr_ptr_ff == {SET_AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // hold the row read until the response register frees up
            if (eval_adv) begin
               ram_wr_en    = 1'b1;
               clock_in     = stamp_new;
               hit_cnt_in   = hit_cnt_ff + COUNT_WIDTH'(hit_any) + COUNT_WIDTH'(is_modify);
               miss_cnt_in  = miss_cnt_ff + COUNT_WIDTH'(!hit_any);
               evict_cnt_in = evict_cnt_ff + COUNT_WIDTH'(evict);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ptr_ff    <= '0;
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_ff       <= WAYS_WIDTH'(1);
         clock_ff      <= '0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         evict_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         clock_ff     <= clock_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SET_BITS:   set_bits_ff   <= csr_wr_data[SET_BITS_WIDTH-1:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_wr_data[BLOCK_BITS_WIDTH-1:0];
               CSR_WAYS:       ways_ff       <= csr_wr_data[WAYS_WIDTH-1:0];
               default: begin
                  // drop writes to unknown indexes
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_kind;
         set_ff  <= req_set;
         tag_ff  <= req_tag;
      end
      if (eval_adv) begin
         rsp_hit_ff     <= hit_any;
         rsp_evicted_ff <= evict;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_hit_total      = hit_cnt_ff;
   assign rsp_miss_total     = miss_cnt_ff;
   assign rsp_eviction_total = evict_cnt_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_CLK(a_take_then_eval, clock, reset, req_take |=> (state_ff == ST_EVAL), "accepted beat did not reach evaluation")
   `ASSERT_CLK(a_rsp_from_eval, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_EVAL), "response raised outside evaluation")
   `ASSERT_CLK(a_hit_not_evict, clock, reset, rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff), "hit reported with an eviction")
   `ASSERT_CLK(a_counts_move, clock, reset, eval_adv |=> (hit_cnt_ff != $past(hit_cnt_ff)) || (miss_cnt_ff != $past(miss_cnt_ff)), "access left hit and miss totals unchanged")
   `ASSERT_CLK(a_evict_only_full, clock, reset, (eval_adv && evict) |-> ($countones(lru_oh) == 1), "eviction without a single oldest way")

endmodule

`default_nettype wire
